>>> src/mrsr_pkg.sv
// mrsr_pkg: types, constants and the crc step for the modbus rtu slave responder
// no dependencies; imported by mrsr_ctrl, mrsr_dpath, the top level and the dv benches
package mrsr_pkg;

   // holding register file
   localparam int NUM_REGS   = 20;
   localparam int MAX_READ   = 20;
   localparam int READ_LIMIT = (NUM_REGS < MAX_READ) ? NUM_REGS : MAX_READ;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int CNT_W      = $clog2(READ_LIMIT + 1);
   // payload bytes of a read reply: address, function, byte count, data
   localparam int POS_W      = $clog2(3 + 2 * READ_LIMIT);

   // function codes and request kinds
   localparam logic       OP_READ  = 1'b0;
   localparam logic       OP_WRITE = 1'b1;
   localparam logic [7:0] FC_READ  = 8'd3;
   localparam logic [7:0] FC_WRITE = 8'd6;

   // writable registers
   localparam logic [7:0] REG_ADDR    = 8'd1;
   localparam logic [7:0] REG_BAUD    = 8'd2;
   localparam logic [7:0] REG_FRAMING = 8'd3;
   localparam logic [7:0] REG_DELAY   = 8'd6;
   localparam logic [7:0] REG_TIMEOUT = 8'd7;

   // accepted value limits
   localparam logic [15:0] ADDR_MAX    = 16'd254;
   localparam logic [15:0] BAUD_MAX    = 16'd2;
   localparam logic [15:0] FRAMING_MAX = 16'd2;
   localparam logic [15:0] DELAY_MAX   = 16'd200;
   localparam logic [15:0] TIMEOUT_MAX = 16'd10;

   // crc-16/modbus
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   typedef struct packed {
      logic       op;
      logic [7:0] slave_addr;
      logic [7:0] reg_hi;
      logic [7:0] reg_lo;
      logic [7:0] val_hi;
      logic [7:0] val_lo;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       link_changed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit_byte;
      logic emit_crc_lo;
      logic emit_crc_hi;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pos_last;
   } stat_type;

   // one byte through the reflected crc, bit by bit
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> src/modbus_rtu_slave_responder_top.sv
// modbus_rtu_slave_responder_top: function 3 / function 6 responder with crc-16/modbus
// depends on mrsr_pkg, mrsr_ctrl and mrsr_dpath
//
//   channel   handshake            payload
//   request   start / busy         req_data  (mrsr_pkg::req_type)
//   reply     rsp_valid (strobe)   rsp_data  (mrsr_pkg::rsp_type)
//
// one reply byte per cycle, back to back, the first passing the state register and the output register after the item
// a reply is 5 + 2 * count bytes for a read (count clamped to 20) and 8 for a write
// busy falls once the final crc byte is registered, so the next item can be taken while
// the last byte of the reply is still on the output, the last byte overlapping the next item
// synchronous reset clears the sequencer, the strobe and the holding register file
// no stalls: the receiver cannot hold bytes off, each is valid for one cycle only
module modbus_rtu_slave_responder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mrsr_pkg::req_type req_data,
   output logic              rsp_valid,
   output mrsr_pkg::rsp_type rsp_data
);
   import mrsr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   mrsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath
   mrsr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // a taken item keeps the block busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after accept");

   // link flag only on the final byte
   a_link_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.link_changed |-> rsp_data.last)
      else $error("link_changed away from last byte");

   // nothing follows the final byte straight away
   a_gap_after_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("byte right after last");

   // bytes before the last only while a reply is in progress
   a_body_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("reply byte while idle");
`endif

endmodule

>>> src/mrsr_ctrl.sv
// mrsr_ctrl: reply sequencer state machine
// depends on mrsr_pkg; drives commands into mrsr_dpath
module mrsr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mrsr_pkg::stat_type stat,
   output mrsr_pkg::cmd_type  cmd,
   output logic               busy
);
   import mrsr_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SEND;
         end
         ST_SEND: begin
            if (stat.pos_last) state_in = ST_CRC_LO;
         end
         ST_CRC_LO: state_in = ST_CRC_HI;
         ST_CRC_HI: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SEND:   cmd.emit_byte   = 1'b1;
         ST_CRC_LO: cmd.emit_crc_lo = 1'b1;
         ST_CRC_HI: cmd.emit_crc_hi = 1'b1;
         default:   busy = 1'b0;
      endcase
   end

endmodule

>>> src/mrsr_dpath.sv
// mrsr_dpath: request register, holding register file, byte select, crc and output register
// depends on mrsr_pkg; commanded by mrsr_ctrl
module mrsr_dpath (
   input  logic              clock,
   input  logic              reset,
   input  mrsr_pkg::req_type req_data,
   input  mrsr_pkg::cmd_type cmd,
   output mrsr_pkg::stat_type stat,
   output logic              rsp_valid,
   output mrsr_pkg::rsp_type rsp_data
);
   import mrsr_pkg::*;

   req_type              req_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     len_m1_ff;
   logic [POS_W-1:0]     len_m1_in;
   logic [15:0]          crc_ff;
   logic                 link_ff;
   logic [15:0]          regs_ff [NUM_REGS];
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [15:0]          wr_val;
   logic                 wr_ok;
   logic                 wr_link;
   logic [POS_W-1:0]     off;
   logic [8:0]           rd_idx;
   logic [15:0]          rd_word;
   logic [7:0]           byte_sel;

   // clamp the read count and work out the payload length
   always_comb begin
      if (req_data.val_lo > 8'(READ_LIMIT)) begin
         cnt_in = CNT_W'(READ_LIMIT);
      end else begin
         cnt_in = req_data.val_lo[CNT_W-1:0];
      end
      if (req_data.op == OP_READ) begin
         len_m1_in = POS_W'(2) + POS_W'({cnt_in, 1'b0});
      end else begin
         len_m1_in = POS_W'(5);
      end
   end

   // write check on the incoming request
   always_comb begin
      wr_val  = {req_data.val_hi, req_data.val_lo};
      wr_ok   = 1'b0;
      wr_link = 1'b0;
      case (req_data.reg_lo)
         REG_ADDR: begin
            wr_ok   = (wr_val >= 16'd1) && (wr_val <= ADDR_MAX);
            wr_link = 1'b1;
         end
         REG_BAUD: begin
            wr_ok   = (wr_val >= 16'd1) && (wr_val <= BAUD_MAX);
            wr_link = 1'b1;
         end
         REG_FRAMING: begin
            wr_ok   = (wr_val >= 16'd1) && (wr_val <= FRAMING_MAX);
            wr_link = 1'b1;
         end
         REG_DELAY:   wr_ok = (wr_val <= DELAY_MAX);
         REG_TIMEOUT: wr_ok = (wr_val >= 16'd1) && (wr_val <= TIMEOUT_MAX);
         default:     wr_ok = 1'b0;
      endcase
   end

   // holding register file, updated when a write request that passes the check is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (cmd.load && req_data.op == OP_WRITE && wr_ok
                   && req_data.reg_lo < 8'(NUM_REGS)) begin
         regs_ff[req_data.reg_lo[REG_IDX_W-1:0]] <= wr_val;
      end
   end

   // register read: two bytes per word after the three header bytes
   always_comb begin
      off    = pos_ff - POS_W'(3);
      rd_idx = {1'b0, req_ff.reg_lo} + 9'(off[POS_W-1:1]);
      if (rd_idx < 9'(NUM_REGS)) begin
         rd_word = regs_ff[rd_idx[REG_IDX_W-1:0]];
      end else begin
         rd_word = '0;
      end
   end

   // payload byte for the current position
   always_comb begin
      byte_sel = req_ff.slave_addr;
      if (req_ff.op == OP_WRITE) begin
         case (pos_ff)
            POS_W'(0): byte_sel = req_ff.slave_addr;
            POS_W'(1): byte_sel = FC_WRITE;
            POS_W'(2): byte_sel = req_ff.reg_hi;
            POS_W'(3): byte_sel = req_ff.reg_lo;
            POS_W'(4): byte_sel = req_ff.val_hi;
            default:   byte_sel = req_ff.val_lo;
         endcase
      end else begin
         case (pos_ff)
            POS_W'(0): byte_sel = req_ff.slave_addr;
            POS_W'(1): byte_sel = FC_READ;
            POS_W'(2): byte_sel = 8'({cnt_ff, 1'b0});
            default:   byte_sel = off[0] ? rd_word[7:0] : rd_word[15:8];
         endcase
      end
   end

   // request, count, position and crc registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         cnt_ff    <= cnt_in;
         len_m1_ff <= len_m1_in;
         pos_ff    <= '0;
         crc_ff    <= CRC_INIT;
         link_ff   <= (req_data.op == OP_WRITE) && wr_ok && wr_link;
      end else if (cmd.emit_byte) begin
         pos_ff <= pos_ff + POS_W'(1);
         crc_ff <= crc_feed(crc_ff, byte_sel);
      end
   end

   // output strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_byte || cmd.emit_crc_lo || cmd.emit_crc_hi;
      end
   end

   // output item
   always_ff @(posedge clock) begin
      if (cmd.emit_byte) begin
         rsp_ff <= '{tx_byte: byte_sel, last: 1'b0, link_changed: 1'b0};
      end else if (cmd.emit_crc_lo) begin
         rsp_ff <= '{tx_byte: crc_ff[7:0], last: 1'b0, link_changed: 1'b0};
      end else if (cmd.emit_crc_hi) begin
         rsp_ff <= '{tx_byte: crc_ff[15:8], last: 1'b1, link_changed: link_ff};
      end
   end

   assign stat.pos_last = (pos_ff == len_m1_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

>>> dv/mrsr_reply_checker.sv
`timescale 1ns / 100ps
// mrsr_reply_checker: watches the request and reply channels, predicts each reply frame
// depends on mrsr_pkg for the channel structs, function codes and register limits
module mrsr_reply_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  mrsr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  mrsr_pkg::rsp_type rsp_data,
   output int unsigned       bytes_owed,
   output int unsigned       fault_count
);
   import mrsr_pkg::*;

   // shadow of the holding register file and the reply bytes still to come
   logic [15:0]  shadow_regs [NUM_REGS];
   rsp_type      reply_q [$];
   int unsigned  owed = 0;
   int unsigned  faults = 0;
   int unsigned  bytes_seen = 0;

   assign bytes_owed  = owed;
   assign fault_count = faults;

   // one line per mismatch, then count it
   task automatic report_fault(input string what, input int unsigned got,
                               input int unsigned want);
      $display("mismatch at %0t, reply byte %0d: %s got %0h, expected %0h",
               $time, bytes_seen, what, got, want);
      faults++;
   endtask

   // crc-16/modbus, reflected, one byte at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // payload byte: queued and folded into the running crc
   task automatic queue_byte(input logic [7:0] b, inout logic [15:0] crc);
      rsp_type e;
      e.tx_byte      = b;
      e.last         = 1'b0;
      e.link_changed = 1'b0;
      reply_q.push_back(e);
      crc = crc16_byte(crc, b);
   endtask

   // trailing crc, low byte first; the high byte closes the frame
   task automatic queue_crc(input logic [15:0] crc, input logic changed);
      rsp_type e;
      e.tx_byte      = crc[7:0];
      e.last         = 1'b0;
      e.link_changed = 1'b0;
      reply_q.push_back(e);
      e.tx_byte      = crc[15:8];
      e.last         = 1'b1;
      e.link_changed = changed;
      reply_q.push_back(e);
   endtask

   // whole reply frame for one accepted item, updating the shadow file on a write
   task automatic predict_reply(input req_type r);
      logic [15:0] crc;
      logic [15:0] val;
      int unsigned cnt;
      int unsigned idx;
      logic        stored;
      logic        link;
      crc = CRC_INIT;
      if (r.op == OP_READ) begin
         cnt = r.val_lo;
         if (cnt > READ_LIMIT) cnt = READ_LIMIT;
         queue_byte(r.slave_addr, crc);
         queue_byte(FC_READ, crc);
         queue_byte(8'(cnt * 2), crc);
         for (int i = 0; i < cnt; i++) begin
            idx = r.reg_lo + i;
            val = (idx < NUM_REGS) ? shadow_regs[idx] : 16'h0000;
            queue_byte(val[15:8], crc);
            queue_byte(val[7:0], crc);
         end
         queue_crc(crc, 1'b0);
      end else begin
         val    = {r.val_hi, r.val_lo};
         stored = 1'b0;
         link   = 1'b0;
         case (r.reg_lo)
            REG_ADDR: begin
               stored = (val >= 16'd1) && (val <= ADDR_MAX);
               link   = 1'b1;
            end
            REG_BAUD: begin
               stored = (val >= 16'd1) && (val <= BAUD_MAX);
               link   = 1'b1;
            end
            REG_FRAMING: begin
               stored = (val >= 16'd1) && (val <= FRAMING_MAX);
               link   = 1'b1;
            end
            REG_DELAY: begin
               stored = (val <= DELAY_MAX);
            end
            REG_TIMEOUT: begin
               stored = (val >= 16'd1) && (val <= TIMEOUT_MAX);
            end
            default: begin
               stored = 1'b0;
            end
         endcase
         if (stored && (r.reg_lo < NUM_REGS)) shadow_regs[r.reg_lo] = val;
         queue_byte(r.slave_addr, crc);
         queue_byte(FC_WRITE, crc);
         queue_byte(r.reg_hi, crc);
         queue_byte(r.reg_lo, crc);
         queue_byte(r.val_hi, crc);
         queue_byte(r.val_lo, crc);
         queue_crc(crc, stored && link);
      end
   endtask

   // one reply byte against the oldest expectation, field by field
   task automatic check_byte(input rsp_type got);
      rsp_type want;
      if (reply_q.size() == 0) begin
         report_fault("byte with nothing expected", got.tx_byte, 0);
      end else begin
         want = reply_q.pop_front();
         if (got.tx_byte !== want.tx_byte)
            report_fault("tx_byte", got.tx_byte, want.tx_byte);
         if (got.last !== want.last)
            report_fault("last", got.last, want.last);
         if (got.link_changed !== want.link_changed)
            report_fault("link_changed", got.link_changed, want.link_changed);
      end
      bytes_seen++;
   endtask

   // results first, then the item taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         reply_q.delete();
         for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = 16'h0000;
      end else begin
         if (rsp_valid) check_byte(rsp_data);
         if (start && !busy) predict_reply(req_data);
      end
      owed <= reply_q.size();
   end

endmodule

>>> dv/modbus_rtu_slave_responder_top_tb.sv
`timescale 1ns / 100ps
// modbus_rtu_slave_responder_top_tb: drives read and write requests into the responder
// depends on mrsr_pkg, modbus_rtu_slave_responder_top and mrsr_reply_checker
module modbus_rtu_slave_responder_top_tb;
   import mrsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int RANDOM_ITEMS   = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int unsigned bytes_owed;
   int unsigned fault_count;
   int unsigned quiet_cycles = 0;
   logic        idling_on = 1'b1;

   always #5 clock = ~clock;

   modbus_rtu_slave_responder_top dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   mrsr_reply_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .bytes_owed (bytes_owed),
      .fault_count(fault_count)
   );

   // watchdog: cycles with neither an item nor a reply byte taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type make_req(input logic op, input logic [7:0] addr,
                                        input logic [7:0] rhi, input logic [7:0] rlo,
                                        input logic [7:0] vhi, input logic [7:0] vlo);
      req_type r;
      r.op         = op;
      r.slave_addr = addr;
      r.reg_hi     = rhi;
      r.reg_lo     = rlo;
      r.val_hi     = vhi;
      r.val_lo     = vlo;
      return r;
   endfunction

   // write mostly to a settings register, values mostly in range, some just outside
   function automatic req_type random_write();
      logic [7:0]  rlo;
      logic [7:0]  rhi;
      logic [15:0] lo_lim;
      logic [15:0] hi_lim;
      logic [15:0] val;
      int unsigned pick;
      rhi = ($urandom_range(99) < 70) ? 8'h00 : 8'($urandom_range(255));
      if ($urandom_range(9) < 8) begin
         pick = $urandom_range(4);
         case (pick)
            0: begin rlo = REG_ADDR;    lo_lim = 16'd1; hi_lim = ADDR_MAX;    end
            1: begin rlo = REG_BAUD;    lo_lim = 16'd1; hi_lim = BAUD_MAX;    end
            2: begin rlo = REG_FRAMING; lo_lim = 16'd1; hi_lim = FRAMING_MAX; end
            3: begin rlo = REG_DELAY;   lo_lim = 16'd0; hi_lim = DELAY_MAX;   end
            default: begin rlo = REG_TIMEOUT; lo_lim = 16'd1; hi_lim = TIMEOUT_MAX; end
         endcase
         pick = $urandom_range(99);
         if (pick < 70) val = 16'($urandom_range(hi_lim, lo_lim));
         else if (pick < 80) val = hi_lim + 16'd1;
         else if (pick < 90) val = lo_lim - 16'd1;
         else val = 16'($urandom_range(16'hFFFF));
      end else begin
         rlo = 8'($urandom_range(255));
         val = 16'($urandom_range(16'hFFFF));
      end
      return make_req(OP_WRITE, 8'($urandom_range(255)), rhi, rlo, val[15:8], val[7:0]);
   endfunction

   // read mostly inside the file with short counts, sometimes anywhere with any count
   function automatic req_type random_read();
      logic [7:0]  rlo;
      logic [7:0]  cnt;
      int unsigned pick;
      rlo  = ($urandom_range(99) < 70) ? 8'($urandom_range(NUM_REGS - 1))
                                       : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 60) cnt = 8'($urandom_range(8));
      else if (pick < 85) cnt = 8'($urandom_range(READ_LIMIT, 9));
      else cnt = 8'($urandom_range(255));
      return make_req(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), rlo,
                      8'($urandom_range(255)), cnt);
   endfunction

   // offer one item, with an occasional gap first, and hold it until taken
   task automatic send_request(input req_type r);
      if (idling_on && ($urandom_range(99) < 24)) begin
         start    <= 1'b0;
         req_data <= req_type'($urandom());
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // hold off until every reply byte owed has come
   task automatic drain_replies();
      start <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and full reads of the cleared file
      send_request(make_req(OP_READ,  8'h11, 8'h00, 8'd0,   8'h00, 8'd0));
      send_request(make_req(OP_READ,  8'hFF, 8'h00, 8'd0,   8'h00, 8'd20));
      // writes at the edges of each accepted range, and just outside
      send_request(make_req(OP_WRITE, 8'h01, 8'h00, REG_ADDR,    8'h00, 8'd1));
      send_request(make_req(OP_WRITE, 8'h00, 8'h00, REG_ADDR,    8'h00, 8'd254));
      send_request(make_req(OP_WRITE, 8'h01, 8'h00, REG_ADDR,    8'h00, 8'd0));
      send_request(make_req(OP_WRITE, 8'h01, 8'h00, REG_ADDR,    8'h00, 8'd255));
      send_request(make_req(OP_WRITE, 8'h01, 8'h00, REG_ADDR,    8'h01, 8'h01));
      send_request(make_req(OP_WRITE, 8'h22, 8'h00, REG_BAUD,    8'h00, 8'd2));
      send_request(make_req(OP_WRITE, 8'h22, 8'h00, REG_BAUD,    8'h00, 8'd3));
      send_request(make_req(OP_WRITE, 8'h33, 8'h00, REG_FRAMING, 8'h00, 8'd1));
      send_request(make_req(OP_WRITE, 8'h33, 8'h00, REG_FRAMING, 8'h00, 8'd0));
      send_request(make_req(OP_WRITE, 8'h44, 8'h00, REG_DELAY,   8'h00, 8'd0));
      send_request(make_req(OP_WRITE, 8'h44, 8'h00, REG_DELAY,   8'h00, 8'd200));
      send_request(make_req(OP_WRITE, 8'h44, 8'h00, REG_DELAY,   8'h00, 8'd201));
      send_request(make_req(OP_WRITE, 8'h55, 8'h00, REG_TIMEOUT, 8'h00, 8'd10));
      send_request(make_req(OP_WRITE, 8'h55, 8'h00, REG_TIMEOUT, 8'h00, 8'd11));
      send_request(make_req(OP_WRITE, 8'h55, 8'h00, REG_TIMEOUT, 8'h00, 8'd0));
      // writes to registers that take nothing
      send_request(make_req(OP_WRITE, 8'h66, 8'h00, 8'd0,   8'h00, 8'd5));
      send_request(make_req(OP_WRITE, 8'h66, 8'h00, 8'd4,   8'h00, 8'd1));
      send_request(make_req(OP_WRITE, 8'h66, 8'h00, 8'd255, 8'hFF, 8'hFF));
      // high register byte is only echoed
      send_request(make_req(OP_WRITE, 8'h77, 8'hFF, REG_BAUD, 8'h00, 8'd1));
      // clamped count, read past the depth, odd fields everywhere
      send_request(make_req(OP_READ,  8'hA5, 8'h00, 8'd0,   8'h00, 8'd255));
      send_request(make_req(OP_READ,  8'h5A, 8'h00, 8'd15,  8'h00, 8'd10));
      send_request(make_req(OP_READ,  8'h00, 8'hFF, 8'd255, 8'hFF, 8'd20));
      send_request(make_req(OP_READ,  8'h80, 8'h00, REG_DELAY, 8'hAA, 8'd2));
      drain_replies();

      // random mix, with a stretch of back-to-back items and one more drain
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idling_on = !((n >= 60) && (n < 120));
         if (n == 90) drain_replies();
         if ($urandom_range(99) < 45) send_request(random_write());
         else send_request(random_read());
      end

      // wait out the last reply and a little more
      drain_replies();
      repeat (8) @(posedge clock);
      if ((fault_count == 0) && (bytes_owed == 0)) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
